### design/key_press_event_queue_core_assert.svh
`ifndef KEY_PRESS_EVENT_QUEUE_CORE_ASSERT_SVH
`define KEY_PRESS_EVENT_QUEUE_CORE_ASSERT_SVH

// Check that prop holds at every edge outside of reset.
`define KPEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define KPEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kpeq_pkg.sv
package kpeq_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int KEY_COUNT_DEF   = 4;

  // Field and register widths
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = CFG_W + 1;
  localparam int KEY_W     = 2;
  localparam int ENTRY_W   = KEY_W + 1;

  // Register reset values
  localparam logic [CFG_W-1:0] DOWN_TIME_RST = 16'd40;
  localparam logic [CFG_W-1:0] HOLD_TIME_RST = 16'd120;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 1'b1;

  // Item commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Event kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // Queue fill marks
  localparam logic [1:0] MARK_EMPTY  = 2'd0;
  localparam logic [1:0] MARK_NORMAL = 2'd1;
  localparam logic [1:0] MARK_FULL   = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [3:0] keys_n;
  } in_t;

  typedef struct packed {
    logic             msg_valid;
    logic [KEY_W-1:0] msg_key;
    logic             msg_kind;
    logic             queue_empty;
    logic             queue_full;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic pop_step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_pop;
    logic last_key;
  } ctrl_status_t;

endpackage

### design/kpeq_stream_if.sv
interface kpeq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kpeq_ram.sv
module kpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/kpeq_datapath.sv
module kpeq_datapath import kpeq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_t                  in_data_i,
  output out_t                 out_data_o,
  input  ctrl_cmd_t            ctrl_i,
  output ctrl_status_t         status_o
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [KIDX_W-1:0] KEY_LAST = KIDX_W'(KEY_COUNT - 1);
  localparam logic [CNT_W-1:0]  CNT_SAT  = CNT_W'(17'h0FFFF);

  logic [CFG_W-1:0]  down_q, down_d, hold_q, hold_d;
  logic [3:0]        keys_q;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic [CNT_W-1:0]  cnt_q [KEY_COUNT];
  logic [CNT_W-1:0]  cnt_new;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_nxt, rd_ptr_nxt;
  logic [1:0]        mark_q, mark_d;
  logic              hit_q, hit_d;
  out_t              out_q;

  logic [3:0]         kidx_ext;
  logic               pressed;
  logic [CNT_W-1:0]   cnt_rd, cnt_inc, down_ext, hold_ext, down_p1, hold_p1;
  logic               push_req, push_kind, push_ok, pop_ok;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;

  // Configuration registers
  always_comb begin
    down_d = down_q;
    hold_d = hold_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DOWN_TIME: down_d = cfg_data_i;
        REG_HOLD_TIME: hold_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Current key level; keys past the four level bits read released
  assign kidx_ext = 4'(kidx_q);
  assign pressed  = (kidx_ext[3:2] == 2'b00) && !keys_q[kidx_ext[1:0]];

  // Saturating press counter step and threshold compares
  assign cnt_rd   = cnt_q[kidx_q];
  assign cnt_inc  = (cnt_rd < CNT_SAT) ? cnt_rd + CNT_W'(1) : cnt_rd;
  assign down_ext = CNT_W'(down_q);
  assign hold_ext = CNT_W'(hold_q);
  assign down_p1  = down_ext + CNT_W'(1);
  assign hold_p1  = hold_ext + CNT_W'(1);

  always_comb begin
    push_req  = 1'b0;
    push_kind = KIND_SHORT;
    cnt_new   = cnt_inc;
    if (!pressed) begin
      cnt_new = '0;
    end else if (cnt_inc <= down_ext) begin
      cnt_new = cnt_inc;
    end else if (cnt_inc == down_p1) begin
      push_req = 1'b1;
    end else if (cnt_inc <= hold_ext) begin
      cnt_new = cnt_inc;
    end else if (cnt_inc == hold_p1) begin
      push_req  = 1'b1;
      push_kind = KIND_LONG;
    end else begin
      // Reload so that long presses repeat
      cnt_new = down_p1;
    end
  end

  // Queue pointers and fill mark
  assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
  assign push_ok    = ctrl_i.scan_step && push_req && (mark_q != MARK_FULL);
  assign pop_ok     = ctrl_i.pop_step && (mark_q != MARK_EMPTY);
  assign wr_entry   = {push_kind, kidx_ext[1:0]};

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    mark_d   = mark_q;
    hit_d    = hit_q;
    kidx_d   = kidx_q;
    if (ctrl_i.accept) begin
      hit_d = 1'b0;
    end
    if (ctrl_i.scan_step) begin
      kidx_d = (kidx_q == KEY_LAST) ? '0 : kidx_q + KIDX_W'(1);
    end
    if (push_ok) begin
      wr_ptr_d = wr_ptr_nxt;
      mark_d   = (wr_ptr_nxt == rd_ptr_q) ? MARK_FULL : MARK_NORMAL;
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_nxt;
      mark_d   = (rd_ptr_nxt == wr_ptr_q) ? MARK_EMPTY : MARK_NORMAL;
      hit_d    = 1'b1;
    end
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q   <= DOWN_TIME_RST;
      hold_q   <= HOLD_TIME_RST;
      kidx_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      mark_q   <= MARK_EMPTY;
      hit_q    <= 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      down_q   <= down_d;
      hold_q   <= hold_d;
      kidx_q   <= kidx_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      mark_q   <= mark_d;
      hit_q    <= hit_d;
      if (ctrl_i.scan_step) begin
        cnt_q[kidx_q] <= cnt_new;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      keys_q <= in_data_i.keys_n;
    end
    if (ctrl_i.load_out) begin
      out_q.msg_valid   <= hit_q;
      out_q.msg_key     <= hit_q ? rd_entry[KEY_W-1:0] : '0;
      out_q.msg_kind    <= hit_q ? rd_entry[KEY_W] : KIND_SHORT;
      out_q.queue_empty <= (mark_q == MARK_EMPTY);
      out_q.queue_full  <= (mark_q == MARK_FULL);
    end
  end

  kpeq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_entry),
    .re_i    (pop_ok),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_entry)
  );

  assign out_data_o         = out_q;
  assign status_o.in_is_pop = (in_data_i.cmd == CMD_POP);
  assign status_o.last_key  = (kidx_q == KEY_LAST);

  `include "key_press_event_queue_core_assert.svh"

  `KPEQ_ASSERT(a_full_ptrs_meet, (mark_q != MARK_FULL) || (wr_ptr_q == rd_ptr_q), "full queue with pointers apart")
  `KPEQ_ASSERT(a_normal_ptrs_apart, (mark_q != MARK_NORMAL) || (wr_ptr_q != rd_ptr_q), "partly filled queue with equal pointers")
  `KPEQ_ASSERT_NEXT(a_full_drops, ctrl_i.scan_step && (mark_q == MARK_FULL), $stable(wr_ptr_q), "write pointer moved on a full queue")

endmodule

### design/kpeq_ctrl.sv
module kpeq_ctrl import kpeq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence one item: accept, work, then hand the result to the output register
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = status_i.in_is_pop ? S_POP : S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (status_i.last_key) begin
          state_d = S_FIN;
        end
      end
      S_POP: begin
        ctrl_o.pop_step = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `include "key_press_event_queue_core_assert.svh"

  `KPEQ_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE, "accepted item left controller idle")
  `KPEQ_ASSERT_NEXT(a_fin_delivers, (state_q == S_FIN) && out_ready_i, out_valid_q && (state_q == S_IDLE), "finished item not delivered")

endmodule

### design/key_press_event_queue_core.sv
// Scan item: after accept, the keys are stepped one key per cycle through the shared press
// counter update unit, then the result is loaded; items are handled one at a time.
// Pop item: the event RAM read is registered before the result is loaded.
// The next item is accepted in the cycle after the previous result is loaded for output.
// Reset (rst_ni low, asynchronous) restores the default thresholds, clears all press counters
// and empties the queue; the event RAM contents are not cleared.
module key_press_event_queue_core import kpeq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  kpeq_stream_if.sink          in_i,
  kpeq_stream_if.source        out_o
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;
  in_t          in_data;
  out_t         out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  kpeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  kpeq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_COUNT   (KEY_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data),
    .out_data_o (out_data),
    .ctrl_i     (ctrl),
    .status_o   (status)
  );

endmodule
